/* src/xalu_pkg.sv */
// ----------------------------------------------------------------------------
// xalu_pkg
// types, operation codes and width helpers for the x86 integer alu
// ----------------------------------------------------------------------------
package xalu_pkg;

    localparam int unsigned DataW = 32;

    typedef enum logic [3:0] {
        OP_ADD   = 4'd0,
        OP_SUB   = 4'd1,
        OP_CMP   = 4'd2,
        OP_INC   = 4'd3,
        OP_DEC   = 4'd4,
        OP_ADC   = 4'd5,
        OP_SBB   = 4'd6,
        OP_MUL   = 4'd7,
        OP_IMUL1 = 4'd8,
        OP_IMUL2 = 4'd9,
        OP_IMUL3 = 4'd10,
        OP_DIV   = 4'd11,
        OP_IDIV  = 4'd12
    } t_op;

    typedef enum logic [1:0] {
        W8  = 2'd0,
        W16 = 2'd1,
        W32 = 2'd2
    } t_width;

    typedef struct packed {
        logic [3:0]       req_type;
        logic [2:0]       op_width;
        logic [2:0]       src_width;
        logic [DataW-1:0] operand_a;
        logic [DataW-1:0] operand_b;
        logic [DataW-1:0] acc_low;
        logic [DataW-1:0] acc_high;
    } t_req;

    typedef struct packed {
        logic [DataW-1:0] result_value;
        logic [DataW-1:0] result_upper;
        logic             dest_written;
        logic             acc_written;
        logic             carry_flag;
        logic             overflow_flag;
        logic             zero_flag;
        logic             sign_flag;
        logic             divide_error;
    } t_rsp;

    // byte count code to width; anything but 1 or 2 is a dword
    function automatic t_width width_dec(input logic [2:0] code);
        t_width w;
        begin
            if (code == 3'd1) begin
                w = W8;
            end else if (code == 3'd2) begin
                w = W16;
            end else begin
                w = W32;
            end
            return w;
        end
    endfunction

    function automatic logic [DataW-1:0] mask_of(input t_width w);
        logic [DataW-1:0] m;
        begin
            unique case (w)
                W8:      m = 32'h0000_00ff;
                W16:     m = 32'h0000_ffff;
                default: m = 32'hffff_ffff;
            endcase
            return m;
        end
    endfunction

    function automatic logic [DataW-1:0] sbit_of(input t_width w);
        logic [DataW-1:0] s;
        begin
            unique case (w)
                W8:      s = 32'h0000_0080;
                W16:     s = 32'h0000_8000;
                default: s = 32'h8000_0000;
            endcase
            return s;
        end
    endfunction

    function automatic logic [DataW-1:0] sext32(input logic [DataW-1:0] v, input t_width w);
        logic [DataW-1:0] r;
        begin
            unique case (w)
                W8:      r = {{24{v[7]}}, v[7:0]};
                W16:     r = {{16{v[15]}}, v[15:0]};
                default: r = v;
            endcase
            return r;
        end
    endfunction

endpackage

/* src/xalu_adder.sv */
// ----------------------------------------------------------------------------
// xalu_adder
// shared 33-bit adder with carry in, used by the sequencer's arithmetic steps
// ----------------------------------------------------------------------------
module xalu_adder (
    input  logic [32:0] i_a,
    input  logic [32:0] i_b,
    input  logic        i_cin,
    output logic [33:0] o_sum
);
    import xalu_pkg::*;

    assign o_sum = {1'b0, i_a} + {1'b0, i_b} + {33'd0, i_cin};

endmodule

/* src/x86_integer_alu_with_flags_top.sv */
// ----------------------------------------------------------------------------
// x86_integer_alu_with_flags_top
// x86 integer alu with cf/of/zf/sf, multiply and divide, one item at a time
// ----------------------------------------------------------------------------
// usage
//   input channel: i_in_valid / o_in_stall carry one t_req beat per operation.
//   output channel: o_out_valid / i_out_stall carry one t_rsp beat per item.
//   o_in_stall is high from the accept until the result is in the output
//   register; the next beat can be taken while that result still waits.
//   everything runs through one 33-bit adder under a small sequencer.
//   steps from accept to result in the output register:
//     add/sub/cmp/inc/dec/adc/sbb and unknown codes: exec, then done
//     mul/imul (all forms): operand negation, 32 shift-add steps of the adder, fix-up
//     div/idiv: negation, a range check, then one quotient bit a cycle over the
//     operand width; a zero divisor or an overflow found early goes straight to done
//   reset (synchronous, active low) clears the four flags, the sequencer
//   and the output valid. while the receiver stalls the output beat holds
//   and a finished item waits in the done state until the register frees.
// ----------------------------------------------------------------------------
module x86_integer_alu_with_flags_top (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  xalu_pkg::t_req i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output xalu_pkg::t_rsp o_out_data
);
    import xalu_pkg::*;

    // sequencer states
    typedef enum logic [9:0] {
        ST_IDLE  = 10'b00_0000_0001,
        ST_EXEC  = 10'b00_0000_0010,
        ST_NEGA  = 10'b00_0000_0100,
        ST_NEGB  = 10'b00_0000_1000,
        ST_NEGH  = 10'b00_0001_0000,
        ST_CHECK = 10'b00_0010_0000,
        ST_ITER  = 10'b00_0100_0000,
        ST_FIXLO = 10'b00_1000_0000,
        ST_FIXHI = 10'b01_0000_0000,
        ST_DONE  = 10'b10_0000_0000
    } t_state;

    t_state      r_state, n_state;
    t_req        r_req,   n_req;
    // working registers: r_x multiplicand / divisor, r_acc product high /
    // remainder, r_q multiplier / quotient / alu result
    logic [31:0] r_x,     n_x;
    logic [32:0] r_acc,   n_acc;
    logic [31:0] r_q,     n_q;
    logic [31:0] r_mask,  n_mask;
    logic [5:0]  r_cnt,   n_cnt;
    logic        r_na,    n_na;
    logic        r_nb,    n_nb;
    logic        r_neg,   n_neg;
    logic        r_xn,    n_xn;
    logic        r_c,     n_c;
    logic        r_err,   n_err;
    logic        r_cf,    n_cf;
    logic        r_of,    n_of;
    logic        r_zf,    n_zf;
    logic        r_sf,    n_sf;
    logic        r_ovalid, n_ovalid;
    t_rsp        r_out,   n_out;

    logic [32:0] add_a, add_b;
    logic        add_cin;
    logic [33:0] add_sum;

    t_width      w, sw;
    logic [31:0] m, sb, am, bm, bmx, alu_res;
    logic [31:0] mx, my, xh, xl, qm;
    logic        is_mul, is_div, is_sgn, q_over;
    t_rsp        rsp;

    xalu_adder u_adder (
        .i_a   (add_a),
        .i_b   (add_b),
        .i_cin (add_cin),
        .o_sum (add_sum)
    );

    assign w       = width_dec(r_req.op_width);
    assign sw      = width_dec(r_req.src_width);
    assign m       = mask_of(w);
    assign sb      = sbit_of(w);
    assign am      = r_req.operand_a & m;
    assign bm      = r_req.operand_b & m;
    assign bmx     = sext32(r_req.operand_b, sw) & m;
    assign alu_res = add_sum[31:0] & m;
    assign is_mul = (r_req.req_type == OP_MUL) || (r_req.req_type == OP_IMUL1)
                 || (r_req.req_type == OP_IMUL2) || (r_req.req_type == OP_IMUL3);
    assign is_div = (r_req.req_type == OP_DIV) || (r_req.req_type == OP_IDIV);
    assign is_sgn = (r_req.req_type != OP_MUL) && (r_req.req_type != OP_DIV);
    assign qm     = r_q & m;
    // signed quotient limit: 2^(w-1) when negative, 2^(w-1)-1 otherwise
    assign q_over = (r_req.req_type == OP_IDIV)
                 && (r_neg ? (|(qm & sb) && |(qm & (m >> 1))) : |(qm & sb));

    // multiply operands as 32-bit values, sign-extended for imul, before magnitudes
    always_comb begin
        unique case (r_req.req_type)
            OP_MUL: begin
                mx = am;
                my = r_req.acc_low & m;
            end
            OP_IMUL1: begin
                mx = sext32(r_req.operand_a, w);
                my = sext32(r_req.acc_low, w);
            end
            OP_IMUL2: begin
                mx = sext32(r_req.operand_b, sw);
                my = sext32(r_req.operand_a, w);
            end
            default: begin
                mx = sext32(r_req.operand_b, sw);
                my = sext32(r_req.operand_a, sw);
            end
        endcase
    end

    // dividend split into high and low halves of the operand width
    always_comb begin
        unique case (w)
            W8: begin
                xh = {24'd0, r_req.acc_low[15:8]};
                xl = {24'd0, r_req.acc_low[7:0]};
            end
            W16: begin
                xh = {16'd0, r_req.acc_high[15:0]};
                xl = {16'd0, r_req.acc_low[15:0]};
            end
            default: begin
                xh = r_req.acc_high;
                xl = r_req.acc_low;
            end
        endcase
    end

    // adder operand selection
    always_comb begin
        add_a   = {1'b0, ~r_q};
        add_b   = '0;
        add_cin = 1'b1;
        unique case (r_state)
            ST_EXEC: begin
                unique case (r_req.req_type)
                    OP_ADD, OP_ADC: begin
                        add_a   = {1'b0, am};
                        add_b   = {1'b0, bm};
                        add_cin = (r_req.req_type == OP_ADC) && r_cf;
                    end
                    OP_SUB, OP_SBB: begin
                        add_a   = {1'b0, am};
                        add_b   = ~{1'b0, bm};
                        add_cin = !((r_req.req_type == OP_SBB) && r_cf);
                    end
                    OP_CMP: begin
                        add_a   = {1'b0, am};
                        add_b   = ~{1'b0, bmx};
                        add_cin = 1'b1;
                    end
                    OP_INC: begin
                        add_a   = {1'b0, am};
                        add_b   = 33'd1;
                        add_cin = 1'b0;
                    end
                    OP_DEC: begin
                        add_a   = {1'b0, am};
                        add_b   = '1;
                        add_cin = 1'b0;
                    end
                    default: begin
                        add_a   = '0;
                        add_b   = '0;
                        add_cin = 1'b0;
                    end
                endcase
            end
            ST_NEGA: begin
                add_a = {1'b0, ~r_x};
            end
            ST_NEGH: begin
                add_a   = {1'b0, ~r_acc[31:0]};
                add_cin = r_c;
            end
            ST_CHECK: begin
                add_a = r_acc;
                add_b = ~{1'b0, r_x};
            end
            ST_ITER: begin
                if (is_div) begin
                    add_a = {r_acc[31:0], r_q[31]};
                    add_b = ~{1'b0, r_x};
                end else begin
                    add_a   = {1'b0, r_acc[31:0]};
                    add_b   = r_q[0] ? {1'b0, r_x} : 33'd0;
                    add_cin = 1'b0;
                end
            end
            ST_FIXHI: begin
                add_a   = {1'b0, ~r_acc[31:0]};
                add_cin = is_div ? 1'b1 : r_c;
            end
            default: begin
                add_a = {1'b0, ~r_q};
            end
        endcase
    end

    // result beat formed from the working registers
    always_comb begin
        rsp               = '0;
        rsp.carry_flag    = r_cf;
        rsp.overflow_flag = r_of;
        rsp.zero_flag     = r_zf;
        rsp.sign_flag     = r_sf;
        unique case (r_req.req_type)
            OP_ADD, OP_SUB, OP_CMP, OP_INC, OP_DEC, OP_ADC, OP_SBB: begin
                rsp.result_value = r_q;
                rsp.dest_written = (r_req.req_type != OP_CMP);
            end
            OP_MUL, OP_IMUL1: begin
                rsp.acc_written = 1'b1;
                unique case (w)
                    W8: begin
                        rsp.result_value = {16'd0, r_q[15:0]};
                    end
                    W16: begin
                        rsp.result_value = {16'd0, r_q[15:0]};
                        rsp.result_upper = {16'd0, r_q[31:16]};
                    end
                    default: begin
                        rsp.result_value = r_q;
                        rsp.result_upper = r_acc[31:0];
                    end
                endcase
            end
            OP_IMUL2, OP_IMUL3: begin
                rsp.result_value = r_q & m;
                rsp.dest_written = 1'b1;
            end
            OP_DIV, OP_IDIV: begin
                if (r_err) begin
                    rsp.divide_error = 1'b1;
                end else begin
                    rsp.acc_written = 1'b1;
                    if (w == W8) begin
                        rsp.result_value = {16'd0, r_acc[7:0], r_q[7:0]};
                    end else begin
                        rsp.result_value = r_q & m;
                        rsp.result_upper = r_acc[31:0] & m;
                    end
                end
            end
            default: begin
                rsp.result_value = '0;
            end
        endcase
    end

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_req    = r_req;
        n_x      = r_x;
        n_acc    = r_acc;
        n_q      = r_q;
        n_mask   = r_mask;
        n_cnt    = r_cnt;
        n_na     = r_na;
        n_nb     = r_nb;
        n_neg    = r_neg;
        n_xn     = r_xn;
        n_c      = r_c;
        n_err    = r_err;
        n_cf     = r_cf;
        n_of     = r_of;
        n_zf     = r_zf;
        n_sf     = r_sf;
        n_out    = r_out;
        n_ovalid = r_ovalid && i_out_stall;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_req   = i_in_data;
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_err = 1'b0;
                n_q   = alu_res;
                if (is_mul) begin
                    n_x     = mx;
                    n_q     = my;
                    n_acc   = '0;
                    n_mask  = '1;
                    n_na    = is_sgn && mx[31];
                    n_nb    = is_sgn && my[31];
                    n_neg   = is_sgn && (mx[31] ^ my[31]);
                    n_state = ST_NEGA;
                end else if (is_div) begin
                    n_x     = am;
                    n_q     = xl;
                    n_acc   = {1'b0, xh};
                    n_mask  = m;
                    n_na    = is_sgn && |(am & sb);
                    n_nb    = is_sgn && |(xh & sb);
                    n_xn    = is_sgn && |(xh & sb);
                    n_neg   = is_sgn && (|(am & sb) ^ |(xh & sb));
                    if (am == '0) begin
                        n_err   = 1'b1;
                        n_state = ST_DONE;
                    end else begin
                        n_state = ST_NEGA;
                    end
                end else begin
                    n_state = ST_DONE;
                    unique case (r_req.req_type)
                        OP_ADD, OP_ADC: begin
                            n_cf = |({1'b0, add_sum[32:0]} & {1'b0, m, 1'b1} & ~{2'b0, m});
                            n_of = |((am ^ alu_res) & (bm ^ alu_res) & sb);
                            n_zf = (alu_res == '0);
                            n_sf = |(alu_res & sb);
                        end
                        OP_SUB, OP_SBB: begin
                            n_cf = !add_sum[33];
                            n_of = |((am ^ bm) & (am ^ alu_res) & sb);
                            n_zf = (alu_res == '0);
                            n_sf = |(alu_res & sb);
                        end
                        OP_CMP: begin
                            n_cf = !add_sum[33];
                            n_of = |((am ^ bmx) & (am ^ alu_res) & sb);
                            n_zf = (alu_res == '0);
                            n_sf = |(alu_res & sb);
                        end
                        OP_INC: begin
                            n_of = (alu_res == sb);
                            n_zf = (alu_res == '0);
                            n_sf = |(alu_res & sb);
                        end
                        OP_DEC: begin
                            n_of = (am == sb);
                            n_zf = (alu_res == '0);
                            n_sf = |(alu_res & sb);
                        end
                        default: begin
                            n_q = '0;
                        end
                    endcase
                end
            end
            ST_NEGA: begin
                if (r_na) begin
                    n_x = add_sum[31:0] & r_mask;
                end
                n_state = ST_NEGB;
            end
            ST_NEGB: begin
                // borrow into the high half when the low half was zero
                n_c = ((r_q & r_mask) == '0);
                if (r_nb) begin
                    n_q = add_sum[31:0] & r_mask;
                end
                if (is_div) begin
                    n_state = ST_NEGH;
                end else begin
                    n_cnt   = 6'd32;
                    n_state = ST_ITER;
                end
            end
            ST_NEGH: begin
                if (r_xn) begin
                    n_acc = {1'b0, add_sum[31:0] & r_mask};
                end
                n_state = ST_CHECK;
            end
            ST_CHECK: begin
                // high half not below divisor: quotient does not fit
                if (add_sum[33]) begin
                    n_err   = 1'b1;
                    n_state = ST_DONE;
                end else begin
                    unique case (w)
                        W8: begin
                            n_q   = {r_q[7:0], 24'd0};
                            n_cnt = 6'd8;
                        end
                        W16: begin
                            n_q   = {r_q[15:0], 16'd0};
                            n_cnt = 6'd16;
                        end
                        default: begin
                            n_cnt = 6'd32;
                        end
                    endcase
                    n_state = ST_ITER;
                end
            end
            ST_ITER: begin
                if (is_div) begin
                    n_acc = add_sum[33] ? add_sum[32:0] : {r_acc[31:0], r_q[31]};
                    n_q   = {r_q[30:0], add_sum[33]};
                end else begin
                    n_acc = {1'b0, add_sum[32:1]};
                    n_q   = {add_sum[0], r_q[31:1]};
                end
                n_cnt = r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    n_state = ST_FIXLO;
                end
            end
            ST_FIXLO: begin
                n_c = (r_q == '0);
                if (is_div && q_over) begin
                    n_err   = 1'b1;
                    n_state = ST_DONE;
                end else begin
                    if (r_neg) begin
                        n_q = add_sum[31:0] & r_mask;
                    end
                    n_state = ST_FIXHI;
                end
            end
            ST_FIXHI: begin
                if (is_div ? r_xn : r_neg) begin
                    n_acc = {1'b0, add_sum[31:0] & r_mask};
                end
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!r_ovalid || !i_out_stall) begin
                    n_out    = rsp;
                    n_ovalid = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
            r_cf     <= 1'b0;
            r_of     <= 1'b0;
            r_zf     <= 1'b0;
            r_sf     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_cf     <= n_cf;
            r_of     <= n_of;
            r_zf     <= n_zf;
            r_sf     <= n_sf;
        end
    end

    // payload and working registers
    always_ff @(posedge i_clk) begin
        r_req  <= n_req;
        r_x    <= n_x;
        r_acc  <= n_acc;
        r_q    <= n_q;
        r_mask <= n_mask;
        r_cnt  <= n_cnt;
        r_na   <= n_na;
        r_nb   <= n_nb;
        r_neg  <= n_neg;
        r_xn   <= n_xn;
        r_c    <= n_c;
        r_err  <= n_err;
        r_out  <= n_out;
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

endmodule

/* dv/xalu_checker.sv */
// ----------------------------------------------------------------------------
// xalu_checker
// watches both channels of the x86 alu, predicts each response beat from
// its own copy of the flags and compares the whole beat
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module xalu_checker
    import xalu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  t_req        i_in_data,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  t_rsp        i_out_data,
    output int unsigned o_fail_count,
    output int unsigned o_pending
);

    logic cf_q, of_q, zf_q, sf_q;
    t_rsp rsp_queue[$];

    function automatic int unsigned bits_of(input logic [2:0] code);
        if (code == 3'd1) return 8;
        if (code == 3'd2) return 16;
        return 32;
    endfunction

    function automatic logic [63:0] sx64(input logic [63:0] v, input int unsigned n);
        logic [63:0] m;
        m = (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
        v = v & m;
        if (n < 64 && v[n-1]) v = v | ~m;
        return v;
    endfunction

    // divide: fills value/upper/acc flag, or raises the error bit
    function automatic void run_divide(input logic [31:0] a, lo, hi, input int unsigned w,
                                       input logic sgn, inout t_rsp r);
        logic [31:0] m;
        logic [63:0] m2, x, d, q, rem, xm, dm, qm, rm, lim;
        logic xn, dn, qn;
        m = 32'hffff_ffff >> (32 - w);
        m2 = (w == 32) ? '1 : ((64'd1 << (2 * w)) - 64'd1);
        if (w == 8) x = {48'd0, lo[15:0]};
        else if (w == 16) x = {32'd0, hi[15:0], lo[15:0]};
        else x = {hi, lo};
        d = {32'd0, a & m};
        if (d == 0) begin
            r.divide_error = 1'b1;
            return;
        end
        if (!sgn) begin
            q = x / d;
            rem = x % d;
            if (q > {32'd0, m}) begin
                r.divide_error = 1'b1;
                return;
            end
        end else begin
            xn = x[2*w-1];
            dn = d[w-1];
            xm = xn ? ((64'd0 - x) & m2) : x;
            dm = dn ? ((64'd0 - d) & {32'd0, m}) : d;
            qm = xm / dm;
            rm = xm % dm;
            qn = xn != dn;
            lim = (64'd1 << (w - 1)) - (qn ? 64'd0 : 64'd1);
            if (qm > lim) begin
                r.divide_error = 1'b1;
                return;
            end
            q = qn ? ((64'd0 - qm) & {32'd0, m}) : qm;
            rem = xn ? ((64'd0 - rm) & {32'd0, m}) : rm;
        end
        if (w == 8) begin
            r.result_value = {16'd0, rem[7:0], q[7:0]};
        end else begin
            r.result_value = q[31:0] & m;
            r.result_upper = rem[31:0] & m;
        end
        r.acc_written = 1'b1;
    endfunction

    // one request in, one response out; flag copy updated on the way
    function automatic t_rsp alu_predict(input t_req q);
        t_rsp        r;
        int unsigned w, sw;
        logic [31:0] m, sb, am, bm, res, c;
        logic [63:0] s, p;
        w = bits_of(q.op_width);
        sw = bits_of(q.src_width);
        m = 32'hffff_ffff >> (32 - w);
        sb = 32'd1 << (w - 1);
        am = q.operand_a & m;
        bm = q.operand_b & m;
        r = '0;
        case (q.req_type)
            OP_ADD, OP_ADC: begin
                c = (q.req_type == OP_ADC) ? {31'd0, cf_q} : 32'd0;
                s = {32'd0, am} + {32'd0, bm} + {32'd0, c};
                res = s[31:0] & m;
                cf_q = s > {32'd0, m};
                of_q = |(((am ^ res) & (bm ^ res)) & sb);
                zf_q = (res == 0);
                sf_q = |(res & sb);
                r.result_value = res;
                r.dest_written = 1'b1;
            end
            OP_SUB, OP_CMP, OP_SBB: begin
                c = (q.req_type == OP_SBB) ? {31'd0, cf_q} : 32'd0;
                if (q.req_type == OP_CMP) begin
                    s = sx64({32'd0, q.operand_b}, sw);
                    bm = s[31:0] & m;
                end
                res = (am - bm - c) & m;
                cf_q = {32'd0, am} < ({32'd0, bm} + {32'd0, c});
                of_q = |(((am ^ bm) & (am ^ res)) & sb);
                zf_q = (res == 0);
                sf_q = |(res & sb);
                r.result_value = res;
                r.dest_written = (q.req_type != OP_CMP);
            end
            OP_INC, OP_DEC: begin
                res = (q.req_type == OP_INC) ? ((am + 1) & m) : ((am - 1) & m);
                of_q = (q.req_type == OP_INC) ? (res == sb) : (am == sb);
                zf_q = (res == 0);
                sf_q = |(res & sb);
                r.result_value = res;
                r.dest_written = 1'b1;
            end
            OP_MUL, OP_IMUL1: begin
                if (q.req_type == OP_MUL) p = {32'd0, am} * {32'd0, q.acc_low & m};
                else p = sx64({32'd0, q.operand_a}, w) * sx64({32'd0, q.acc_low}, w);
                if (w == 8) begin
                    r.result_value = {16'd0, p[15:0]};
                end else if (w == 16) begin
                    r.result_value = {16'd0, p[15:0]};
                    r.result_upper = {16'd0, p[31:16]};
                end else begin
                    r.result_value = p[31:0];
                    r.result_upper = p[63:32];
                end
                r.acc_written = 1'b1;
            end
            OP_IMUL2, OP_IMUL3: begin
                if (q.req_type == OP_IMUL2)
                    p = sx64({32'd0, q.operand_b}, sw) * sx64({32'd0, q.operand_a}, w);
                else
                    p = sx64({32'd0, q.operand_b}, sw) * sx64({32'd0, q.operand_a}, sw);
                r.result_value = p[31:0] & m;
                r.dest_written = 1'b1;
            end
            OP_DIV, OP_IDIV: begin
                run_divide(q.operand_a, q.acc_low, q.acc_high, w, q.req_type == OP_IDIV, r);
            end
            default: ;
        endcase
        r.carry_flag = cf_q;
        r.overflow_flag = of_q;
        r.zero_flag = zf_q;
        r.sign_flag = sf_q;
        return r;
    endfunction

    assign o_pending = rsp_queue.size();

    always @(posedge i_clk) begin
        t_rsp want;
        if (!i_rst_n) begin
            cf_q <= 1'b0;
            of_q <= 1'b0;
            zf_q <= 1'b0;
            sf_q <= 1'b0;
            rsp_queue.delete();
            o_fail_count <= 0;
        end else begin
            // response side first: a result never comes out in its own accept beat
            if (i_out_valid && !i_out_stall) begin
                if (rsp_queue.size() == 0) begin
                    $display("%0t: unexpected response beat, actual %p", $time, i_out_data);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = rsp_queue.pop_front();
                    if (want !== i_out_data) begin
                        $display("%0t: response mismatch, expected %p, actual %p",
                                 $time, want, i_out_data);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) rsp_queue.push_back(alu_predict(i_in_data));
        end
    end

endmodule

/* dv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// drives directed and random alu requests with random gaps and stalls, the
// checker beside the block predicts and compares every response beat
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
    import xalu_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    t_req        in_data = '0;
    logic        out_valid;
    logic        out_stall = 1'b1;
    t_rsp        out_data;
    int unsigned fail_count;
    int unsigned pending;
    bit          stim_done = 1'b0;

    // free-running clock, 8 ns period
    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    x86_integer_alu_with_flags_top i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    xalu_checker i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // edge-heavy operand values
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 32'd0;
            1: return 32'hffff_ffff;
            2: return 32'h8000_0000 >> (8 * $urandom_range(0, 3));
            3: return (32'h7fff_ffff >> (8 * $urandom_range(0, 3)));
            4: return $urandom_range(0, 3);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [2:0] pick_width();
        // mostly legal widths, now and then the odd codes that decode as dword
        case ($urandom_range(0, 9))
            0: return 3'($urandom_range(0, 7));
            1, 2, 3: return 3'd1;
            4, 5, 6: return 3'd2;
            default: return 3'd4;
        endcase
    endfunction

    function automatic t_req random_req();
        t_req q;
        q.req_type = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(13, 15))
                                                  : 4'($urandom_range(0, 12));
        q.op_width = pick_width();
        q.src_width = pick_width();
        q.operand_a = pick_value();
        q.operand_b = pick_value();
        q.acc_low = pick_value();
        q.acc_high = pick_value();
        // keep most divides in range so the quotient path is exercised
        if ((q.req_type == OP_DIV || q.req_type == OP_IDIV) && $urandom_range(0, 3) != 0)
            q.acc_high = $urandom_range(0, 1) ? 32'd0 : 32'hffff_ffff;
        return q;
    endfunction

    // one request beat: optional idle gap, then hold valid until accepted
    task automatic send_beat(input t_req q, input int unsigned gap);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_data <= q;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
    endtask

    function automatic t_req mk(input t_op op, input logic [2:0] w, sw,
                                input logic [31:0] a, b, lo, hi);
        t_req q;
        q = '{req_type: op, op_width: w, src_width: sw, operand_a: a,
              operand_b: b, acc_low: lo, acc_high: hi};
        return q;
    endfunction

    // receiver: random stall per beat, with one long hold-off after 220 beats
    initial begin
        int unsigned wait_cycles;
        int unsigned beats;
        beats = 0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (beats == 220) begin
                out_stall <= 1'b1;
                repeat (300) @(negedge clk);
            end
            wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
            if (wait_cycles == 0) begin
                out_stall <= 1'b0;
            end else begin
                out_stall <= 1'b1;
                repeat (wait_cycles - 1) @(negedge clk);
                @(negedge clk);
                out_stall <= 1'b0;
            end
            // wait for the beat to go through
            @(posedge clk);
            while (!(out_valid && !out_stall)) @(posedge clk);
            beats++;
        end
    end

    initial begin
        t_req        directed[$];
        int unsigned gap;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: extremes, every operation, flag carry-in, divide errors
        directed.push_back(mk(OP_ADD, 3'd1, 3'd1, 32'hff, 32'h01, 0, 0));
        directed.push_back(mk(OP_ADC, 3'd1, 3'd1, 32'h7f, 32'h00, 0, 0));
        directed.push_back(mk(OP_ADD, 3'd4, 3'd4, 32'h7fff_ffff, 32'h1, 0, 0));
        directed.push_back(mk(OP_SUB, 3'd2, 3'd2, 32'h0, 32'h1, 0, 0));
        directed.push_back(mk(OP_SBB, 3'd2, 3'd2, 32'h8000, 32'h0, 0, 0));
        directed.push_back(mk(OP_CMP, 3'd4, 3'd1, 32'h0, 32'h80, 0, 0));
        directed.push_back(mk(OP_CMP, 3'd2, 3'd1, 32'hffff, 32'hff, 0, 0));
        directed.push_back(mk(OP_INC, 3'd1, 3'd1, 32'h7f, 0, 0, 0));
        directed.push_back(mk(OP_DEC, 3'd4, 3'd4, 32'h8000_0000, 0, 0, 0));
        directed.push_back(mk(OP_INC, 3'd4, 3'd4, 32'hffff_ffff, 0, 0, 0));
        directed.push_back(mk(OP_MUL, 3'd4, 3'd4, 32'hffff_ffff, 0, 32'hffff_ffff, 0));
        directed.push_back(mk(OP_MUL, 3'd1, 3'd1, 32'hff, 0, 32'hff, 0));
        directed.push_back(mk(OP_IMUL1, 3'd2, 3'd2, 32'h8000, 0, 32'h8000, 0));
        directed.push_back(mk(OP_IMUL2, 3'd4, 3'd1, 32'hffff_fffe, 32'h80, 0, 0));
        directed.push_back(mk(OP_IMUL3, 3'd2, 3'd1, 32'h81, 32'hff, 0, 0));
        directed.push_back(mk(OP_DIV, 3'd1, 3'd1, 32'h0, 0, 32'h1234, 0));
        directed.push_back(mk(OP_DIV, 3'd1, 3'd1, 32'h1, 0, 32'h0100, 0));
        directed.push_back(mk(OP_DIV, 3'd4, 3'd4, 32'hffff_ffff, 0, 32'hffff_ffff,
                              32'hffff_fffe));
        directed.push_back(mk(OP_IDIV, 3'd1, 3'd1, 32'hff, 0, 32'hff80, 0));
        directed.push_back(mk(OP_IDIV, 3'd1, 3'd1, 32'hff, 0, 32'h0080, 0));
        directed.push_back(mk(OP_IDIV, 3'd2, 3'd2, 32'h7, 0, 32'hfff9, 32'hffff));
        directed.push_back(mk(OP_IDIV, 3'd4, 3'd4, 32'hffff_ffff, 0, 32'h8000_0000,
                              32'hffff_ffff));
        directed.push_back(mk(t_op'(4'd15), 3'd0, 3'd7, 32'hffff_ffff, 32'hffff_ffff,
                              32'hffff_ffff, 32'hffff_ffff));
        directed.push_back(mk(OP_SUB, 3'd3, 3'd0, 32'h0, 32'h0, 0, 0));
        foreach (directed[k]) send_beat(directed[k], 0);

        // random phase; back-to-back offers around the receiver hold-off,
        // and one sender pause until every result is back
        for (int n = 0; n < 1200; n++) begin
            if (n == 600) begin
                in_valid <= 1'b0;
                wait (pending == 0);
                @(negedge clk);
            end
            gap = ($urandom_range(0, 2) == 0 || (n >= 190 && n < 260))
                  ? 0 : $urandom_range(0, 13);
            send_beat(random_req(), gap);
        end
        in_valid <= 1'b0;
        stim_done = 1'b1;
    end

    // verdict once everything is back and the block has settled
    initial begin
        wait (stim_done);
        wait (pending == 0);
        repeat (60) @(posedge clk);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // watchdog: 1224 beats, each at worst a full divide plus a gap and a stall, plus one hold-off
    initial begin
        #3_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

/* sim.f */
src/xalu_pkg.sv
src/xalu_adder.sv
src/x86_integer_alu_with_flags_top.sv
dv/xalu_checker.sv
dv/testbench.sv
